// File: design/aas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package aas_pkg;

  localparam int unsigned MAX_STEPS  = 8;
  localparam int unsigned DATA_WIDTH = 16;
  localparam logic [15:0] VCAP = 16'((32'd1 << (DATA_WIDTH - 1)) - 32'd1);

  // configuration register indexes
  localparam logic [2:0] CFG_STEP_PLAN  = 3'd0;
  localparam logic [2:0] CFG_GAIN_FAR   = 3'd1;
  localparam logic [2:0] CFG_GAIN_NEAR  = 3'd2;
  localparam logic [2:0] CFG_TRANS_DIST = 3'd3;
  localparam logic [2:0] CFG_DECEL_DIST = 3'd4;
  localparam logic [2:0] CFG_LAT_LIM    = 3'd5;
  localparam logic [2:0] CFG_LON_LIM    = 3'd6;
  localparam logic [2:0] CFG_YAW_LIM    = 3'd7;

  // motion modes
  localparam logic [1:0] MODE_STILL = 2'd0;
  localparam logic [1:0] MODE_ROT   = 2'd1;
  localparam logic [1:0] MODE_LAT   = 2'd2;
  localparam logic [1:0] MODE_LON   = 2'd3;

  // step codes
  localparam logic [1:0] STEP_YAW  = 2'd0;
  localparam logic [1:0] STEP_LAT  = 2'd1;
  localparam logic [1:0] STEP_LON  = 2'd2;
  localparam logic [1:0] STEP_DIFF = 2'd3;

  // sequence phases
  localparam logic [1:0] PH_INIT   = 2'd0;
  localparam logic [1:0] PH_RUN    = 2'd1;
  localparam logic [1:0] PH_FINISH = 2'd2;

  // diff-lateral phases
  localparam logic [2:0] DP_IDLE    = 3'd0;
  localparam logic [2:0] DP_ROTATE  = 3'd1;
  localparam logic [2:0] DP_DRIVE   = 3'd2;
  localparam logic [2:0] DP_RESTORE = 3'd3;
  localparam logic [2:0] DP_DONE    = 3'd4;

  typedef enum logic [2:0] {
    SEL_YAW   = 3'd0,
    SEL_LAT   = 3'd1,
    SEL_LON   = 3'd2,
    SEL_HEAD  = 3'd3,
    SEL_DRIVE = 3'd4
  } axis_sel_e;

  typedef struct packed {
    logic              req_type;
    logic [1:0]        actual_mode;
    logic signed [15:0] lateral_offset;
    logic signed [15:0] longitudinal_offset;
    logic signed [15:0] yaw_offset;
    logic signed [15:0] heading_angle;
  } aas_in_t;

  typedef struct packed {
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] vel_z;
    logic [1:0]         wanted_mode;
    logic               align_done;
    logic               in_progress;
  } aas_out_t;

  typedef struct packed {
    logic [15:0] gain_far;
    logic [15:0] gain_near;
    logic [14:0] transition_dist;
    logic [14:0] decel_dist;
    logic [47:0] lateral_limits;
    logic [47:0] longitudinal_limits;
    logic [47:0] yaw_limits;
  } aas_cfg_t;

  typedef struct packed {
    logic      capture;
    axis_sel_e sel;
    logic      rule_commit;
    logic      clear_vel;
    logic      set_mode;
    logic [1:0] mode;
    logic      set_done;
    logic      clr_done;
    logic      prog;
    logic      emit;
  } aas_cmd_t;

  typedef struct packed {
    logic dead;
    logic mag_zero;
    logic out_free;
  } aas_sts_t;

endpackage
`default_nettype wire

// File: design/aas_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module aas_dp #(
  parameter int unsigned DATA_WIDTH = aas_pkg::DATA_WIDTH
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire aas_pkg::aas_in_t  in_data_i,
  input  wire aas_pkg::aas_cfg_t cfg_i,
  input  wire aas_pkg::aas_cmd_t cmd_i,
  output aas_pkg::aas_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output aas_pkg::aas_out_t      out_data_o
);
  import aas_pkg::*;

  // largest speed magnitude the velocity word may carry
  localparam logic [31:0] VCAP_W = 32'((64'd1 << (DATA_WIDTH - 1)) - 64'd1);

  logic signed [15:0] err_q;
  axis_sel_e          sel_q;
  logic [31:0]        prod_q;
  logic [19:0]        s_q;
  logic [39:0]        sq_q;
  logic [47:0]        cube_q;
  logic [15:0]        last_q, last_d;
  logic [15:0]        vx_q, vx_d, vy_q, vy_d, vz_q, vz_d;
  logic [1:0]         mode_q, mode_d;
  logic               done_q, done_d;
  logic               out_valid_q;
  aas_out_t           out_q;

  logic [15:0] eabs, dead_lim, smin, smax, gain, mag, vel;
  logic [47:0] lim;
  logic        far, decel, dead;
  logic [27:0] sq_sat;
  logic [17:0] smin3;
  logic [39:0] t, s1, s2;
  logic [15:0] s3;

  // pick the limits for the active axis
  always_comb begin
    case (sel_q)
      SEL_LAT, SEL_DRIVE: lim = cfg_i.lateral_limits;
      SEL_LON:            lim = cfg_i.longitudinal_limits;
      default:            lim = cfg_i.yaw_limits;
    endcase
  end

  assign eabs     = err_q[15] ? 16'(-err_q) : 16'(err_q);
  assign dead_lim = lim[15:0];
  assign smin     = lim[31:16];
  assign smax     = lim[47:32];
  assign far      = {1'b0, eabs} > {2'b0, cfg_i.transition_dist};
  assign decel    = {1'b0, eabs} < {2'b0, cfg_i.decel_dist};
  assign dead     = eabs <= dead_lim;
  assign gain     = far ? cfg_i.gain_far : cfg_i.gain_near;
  assign sq_sat   = (sq_q >= 40'h800_0000) ? 28'h800_0000 : {1'b0, sq_q[26:0]};

  // capture the error and run the multiply chain
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sel_q <= cmd_i.sel;
      case (cmd_i.sel)
        SEL_YAW:            err_q <= in_data_i.yaw_offset;
        SEL_LAT, SEL_DRIVE: err_q <= in_data_i.lateral_offset;
        SEL_LON:            err_q <= in_data_i.longitudinal_offset;
        default:            err_q <= in_data_i.heading_angle;
      endcase
    end
    prod_q <= {16'b0, gain} * {16'b0, eabs};
    s_q    <= prod_q[31:12];
    sq_q   <= {20'b0, prod_q[31:12]} * {20'b0, prod_q[31:12]};
    cube_q <= {20'b0, sq_sat} * {28'b0, s_q};
  end

  // speed rule: decay, jump hold, clamps
  always_comb begin
    smin3 = ({2'b0, smin} << 1) + {2'b0, smin};
    t     = decel ? cube_q[47:8] : {20'b0, s_q};
    if (far) s1 = {20'b0, s_q};
    else if (t > {22'b0, smin3}) s1 = {24'b0, last_q};
    else s1 = t;
    s2 = (s1 < {24'b0, smin}) ? {24'b0, smin} : s1;
    s3 = (s2 > {24'b0, smax}) ? smax : s2[15:0];
    if ({16'b0, s3} > VCAP_W) s3 = VCAP_W[15:0];
    mag = dead ? 16'd0 : s3;
    vel = (!err_q[15] && (err_q != 16'sd0)) ? 16'(-mag) : mag;
  end

  // next held state
  always_comb begin
    vx_d = vx_q; vy_d = vy_q; vz_d = vz_q;
    mode_d = mode_q; done_d = done_q; last_d = last_q;
    if (cmd_i.rule_commit) begin
      last_d = mag;
      case (sel_q)
        SEL_LAT:            vx_d = vel;
        SEL_LON, SEL_DRIVE: vy_d = vel;
        default:            vz_d = vel;
      endcase
    end
    if (cmd_i.clear_vel) begin
      vx_d = '0; vy_d = '0; vz_d = '0;
    end
    if (cmd_i.set_mode) mode_d = cmd_i.mode;
    if (cmd_i.set_done) done_d = 1'b1;
    if (cmd_i.clr_done) done_d = 1'b0;
  end

  // commit state and load the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= '0; vy_q <= '0; vz_q <= '0;
      mode_q <= MODE_STILL; done_q <= 1'b0; last_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        vx_q <= vx_d; vy_q <= vy_d; vz_q <= vz_d;
        mode_q <= mode_d; done_q <= done_d; last_q <= last_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.vel_x       <= vx_d;
      out_q.vel_y       <= vy_d;
      out_q.vel_z       <= vz_d;
      out_q.wanted_mode <= mode_d;
      out_q.align_done  <= done_d;
      out_q.in_progress <= cmd_i.prog;
    end
  end

  assign sts_o.dead     = dead;
  assign sts_o.mag_zero = (mag == 16'd0);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

// File: design/aas_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module aas_ctrl #(
  parameter int unsigned MAX_STEPS = aas_pkg::MAX_STEPS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              req_type_i,
  input  wire logic [1:0]        actual_mode_i,
  input  wire logic [19:0]       step_plan_i,
  input  wire aas_pkg::aas_sts_t sts_i,
  output aas_pkg::aas_cmd_t      cmd_o
);
  import aas_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL1 = 5'b00010,
    S_MUL2 = 5'b00100,
    S_MUL3 = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] phase_q, phase_d;
  logic [3:0] idx_q, idx_d;
  logic [2:0] diff_q, diff_d;
  logic       req_q;
  logic [1:0] am_q;

  logic [3:0] count;
  logic [1:0] code;
  logic       at_end;
  axis_sel_e  sel;
  logic [1:0] want;
  logic       accept;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  // decode the current step
  always_comb begin
    count  = (step_plan_i[3:0] > 4'(MAX_STEPS)) ? 4'(MAX_STEPS) : step_plan_i[3:0];
    code   = step_plan_i[4 + 2 * idx_q[2:0] +: 2];
    at_end = idx_q >= count;
    sel    = SEL_YAW;
    want   = MODE_ROT;
    case (code)
      STEP_LAT: begin sel = SEL_LAT; want = MODE_LAT; end
      STEP_LON: begin sel = SEL_LON; want = MODE_LON; end
      STEP_DIFF: begin
        if (diff_q == DP_DRIVE) begin
          sel = SEL_DRIVE; want = MODE_LON;
        end else begin
          sel = SEL_HEAD; want = MODE_ROT;
        end
      end
      default: begin sel = SEL_YAW; want = MODE_ROT; end
    endcase
  end

  // sequence commands and the next phase on the commit cycle
  always_comb begin
    state_d = state_q;
    phase_d = phase_q; idx_d = idx_q; diff_d = diff_q;
    cmd_o = '0;
    cmd_o.capture = accept;
    cmd_o.sel     = sel;
    cmd_o.mode    = want;
    cmd_o.prog    = 1'b1;
    case (state_q)
      S_IDLE: if (accept) state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_MUL3;
      S_MUL3: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          if (req_q) begin
            phase_d = PH_INIT; idx_d = '0; diff_d = DP_IDLE;
            cmd_o.clr_done = 1'b1; cmd_o.clear_vel = 1'b1;
          end else if (phase_q == PH_RUN) begin
            if (at_end) begin
              phase_d = PH_FINISH;
            end else if (code != STEP_DIFF) begin
              cmd_o.set_mode = 1'b1;
              if (am_q == want) begin
                cmd_o.rule_commit = 1'b1;
                if (sts_i.dead) idx_d = idx_q + 4'd1;
              end
            end else begin
              case (diff_q)
                DP_ROTATE, DP_DRIVE, DP_RESTORE: begin
                  cmd_o.set_mode = 1'b1;
                  if (am_q == want) begin
                    cmd_o.rule_commit = 1'b1;
                    if (diff_q == DP_RESTORE) begin
                      if (sts_i.dead) diff_d = DP_DONE;
                    end else if (sts_i.mag_zero) begin
                      diff_d = diff_q + 3'd1;
                    end
                  end
                end
                DP_DONE: idx_d = idx_q + 4'd1;
                default: diff_d = DP_ROTATE;
              endcase
            end
          end else if (phase_q == PH_FINISH) begin
            cmd_o.prog = 1'b0;
            phase_d = PH_INIT; idx_d = '0; diff_d = DP_IDLE;
            cmd_o.clear_vel = 1'b1; cmd_o.set_done = 1'b1;
          end else begin
            cmd_o.clear_vel = 1'b1;
            cmd_o.set_mode  = 1'b1;
            cmd_o.mode      = MODE_STILL;
            idx_d = '0; phase_d = PH_RUN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_INIT;
      idx_q   <= '0;
      diff_q  <= DP_IDLE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      diff_q  <= diff_d;
    end
  end

  // hold the request kind and reported mode of the beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      am_q  <= actual_mode_i;
    end
  end

endmodule
`default_nettype wire

// File: design/axis_alignment_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_stall_o      aas_in_t tick or restart
// out       output     out_valid_o / out_stall_i    aas_out_t velocities, mode, flags
// cfg       input      cfg_we_i, cfg_addr_i         cfg_wdata_i, 48 bits
//
// The result beat is loaded once the error is captured, the gain, square
// and cube multiplies register in turn and the result register is free.
// One beat is in work at a time, so a new beat is taken only after the last
// one is emitted; it is taken while the result register still waits.
// Reset clears all sequence state, held velocities and configuration.
// A stalled output holds the commit cycle until the result register frees.
module axis_alignment_sequencer #(
  parameter int unsigned MAX_STEPS  = aas_pkg::MAX_STEPS,
  parameter int unsigned DATA_WIDTH = aas_pkg::DATA_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire aas_pkg::aas_in_t in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output aas_pkg::aas_out_t     out_data_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_addr_i,
  input  wire logic [47:0]      cfg_wdata_i
);
  import aas_pkg::*;

  logic [19:0] plan_q;
  aas_cfg_t    cfg_q;
  aas_cmd_t    cmd;
  aas_sts_t    sts;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plan_q <= '0;
      cfg_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_STEP_PLAN:  plan_q                    <= cfg_wdata_i[19:0];
        CFG_GAIN_FAR:   cfg_q.gain_far            <= cfg_wdata_i[15:0];
        CFG_GAIN_NEAR:  cfg_q.gain_near           <= cfg_wdata_i[15:0];
        CFG_TRANS_DIST: cfg_q.transition_dist     <= cfg_wdata_i[14:0];
        CFG_DECEL_DIST: cfg_q.decel_dist          <= cfg_wdata_i[14:0];
        CFG_LAT_LIM:    cfg_q.lateral_limits      <= cfg_wdata_i;
        CFG_LON_LIM:    cfg_q.longitudinal_limits <= cfg_wdata_i;
        CFG_YAW_LIM:    cfg_q.yaw_limits          <= cfg_wdata_i;
        default:        plan_q                    <= plan_q;
      endcase
    end
  end

  aas_ctrl #(
    .MAX_STEPS (MAX_STEPS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (in_data_i.req_type),
    .actual_mode_i (in_data_i.actual_mode),
    .step_plan_i   (plan_q),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  aas_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
